// ----- rtl/core/cbe_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbe_pkg
// Shared types and fixed-point constants of the contact bounce envelope.
// ============================================================================
package cbe_pkg;

    // Fixed-point scale: 32768 stands for 1.0.
    localparam logic [15:0] ONE_FX  = 16'd32768;
    localparam logic [15:0] HALF_FX = 16'd16384;

    // Phase limits of the 17-bit signed phase register.
    localparam int PHASE_MAX_I = 65535;
    localparam int PHASE_MIN_I = -65536;

    // Elapsed counter ceiling.
    localparam logic [16:0] CNT17_MAX = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic [2:0] REG_HIGH   = 3'd0;
    localparam logic [2:0] REG_LOW    = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_DECAY  = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;
    localparam logic [2:0] REG_RAMP   = 3'd5;
    localparam logic [2:0] REG_MAXLEN = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] RST_HIGH   = 16'd1638;
    localparam logic [15:0] RST_LOW    = 16'd492;
    localparam logic [13:0] RST_STEP   = 14'd967;
    localparam logic [15:0] RST_DECAY  = 16'd16384;
    localparam logic [15:0] RST_SCALE  = 16'd9830;
    localparam logic [15:0] RST_RAMP   = 16'd0;
    localparam logic [15:0] RST_MAXLEN = 16'd8192;

    // Item kinds carried in the input tuser bit.
    localparam logic MODE_TRIGGER = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_DELAY  = 2'd0;
    localparam logic [1:0] ST_BOUNCE = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    // One registered input request.
    typedef struct packed {
        logic              mode;
        logic signed [7:0] velocity;
        logic [15:0]       start_delay;
    } t_in_item;

    // Amplitude for a trigger: floor(v * 32768 / 127), zero for v <= 0.
    // 32768 = 127 * 258 + 2, so the quotient is 258*v plus floor(2v / 127).
    function automatic logic [15:0] vel_to_amp(input logic signed [7:0] vel);
        logic [6:0]  mag;
        logic [15:0] base;
        logic [15:0] corr;
        mag  = vel[6:0];
        base = 16'(mag) * 16'd258;
        if (mag == 7'd127) begin
            corr = 16'd2;
        end else if (mag >= 7'd64) begin
            corr = 16'd1;
        end else begin
            corr = 16'd0;
        end
        if (vel[7] || (vel == 8'sd0)) begin
            vel_to_amp = 16'd0;
        end else begin
            vel_to_amp = base + corr;
        end
    endfunction

endpackage

// ----- rtl/core/contact_bounce_envelope_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// contact_bounce_envelope_top
// Key-contact bounce envelope generator, one envelope sample per trigger or tick request.
// ============================================================================
//
//  Channel   Direction  Signals                    Content
//  --------  ---------  -------------------------  ------------------------------
//  s_axis    in         tvalid tready tdata tuser  trigger or tick request
//  m_axis    out        tvalid tready tdata tuser  envelope sample and status
//  cfg       in         valid ready index data     register writes, always ready
//
//  Each request passes through the input register, then through the evaluation
//  logic into the result register. A new request is taken every cycle while the
//  output is not stalled; the throughput is set by the single evaluation stage,
//  whose longest path is the 17x18 position multiply and threshold compare. Reset
//  is synchronous and active low and returns the valid flags, envelope state and
//  configuration registers to their defaults. A stalled result holds its register;
//  the input register keeps accepting while the result register is free or drained.
// ============================================================================
module contact_bounce_envelope_top
    import cbe_pkg::*;
#(
    parameter int CONTACT_PERIOD = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] velocity, [23:8] start_delay
    input  logic        s_axis_tuser,   // [0] mode
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] envelope
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int PairW = $clog2(CONTACT_PERIOD);
    localparam int StepW = 14 + $clog2(CONTACT_PERIOD);
    localparam int SumW  = StepW + 4;
    localparam logic [PairW-1:0] PairLast = PairW'(CONTACT_PERIOD - 1);
    localparam logic signed [SumW-1:0] PhMax = SumW'(PHASE_MAX_I);
    localparam logic signed [SumW-1:0] PhMin = SumW'(PHASE_MIN_I);

    // Configuration registers
    logic [15:0] r_high, r_low, r_decay, r_scale, r_ramp, r_maxlen;
    logic [13:0] r_step;

    // Input stage
    logic     r_in_valid;
    t_in_item r_in;

    // Envelope state
    logic [15:0]        r_amp;
    logic signed [16:0] r_phase;
    logic               r_closed;
    logic [15:0]        r_held;
    logic [PairW-1:0]   r_pair;
    logic [15:0]        r_delay;
    logic [16:0]        r_budget;
    logic [16:0]        r_elapsed;

    // Result stage
    logic        r_out_valid;
    logic [15:0] r_out_env;
    logic [1:0]  r_out_status;

    // Next-state values
    logic [15:0]        n_amp;
    logic signed [16:0] n_phase;
    logic               n_closed;
    logic [15:0]        n_held;
    logic [PairW-1:0]   n_pair;
    logic [15:0]        n_delay;
    logic [16:0]        n_budget;
    logic [16:0]        n_elapsed;
    logic [15:0]        n_env;
    logic [1:0]         n_status;

    // Evaluation datapath
    logic                   out_free;
    logic                   fire;
    logic signed [17:0]     tri_val;
    logic signed [34:0]     pos_prod;
    logic signed [34:0]     pos_round;
    logic signed [19:0]     pos;
    logic [31:0]            dec_prod;
    logic [16:0]            dec_amp;
    logic signed [16:0]     ph_base;
    logic [StepW-1:0]       step_amt;
    logic signed [SumW-1:0] ph_sum;
    logic signed [17:0]     trig_diff;
    logic [15:0]            open_level;
    logic                   wrap;
    logic                   eval_closed;
    logic [15:0]            eval_level;

    // Handshakes: the input register moves on when the result register frees.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_env;
    assign m_axis_tuser  = r_out_status;

    // Contact position: amplitude times triangle of phase, truncated toward zero.
    always_comb begin
        if (r_phase[16]) begin
            tri_val = 18'sd32768 + {r_phase, 1'b0};
        end else begin
            tri_val = 18'sd32768 - {r_phase, 1'b0};
        end
        pos_prod  = $signed({1'b0, r_amp}) * tri_val;
        pos_round = pos_prod + (pos_prod[34] ? 35'sd32767 : 35'sd0);
        pos       = pos_round[34:15];
    end

    // Amplitude decay, phase wrap and phase advance.
    always_comb begin
        wrap     = (r_phase > 17'sd16384);
        dec_prod = r_amp * r_decay;
        dec_amp  = dec_prod[31:15];
        ph_base  = wrap ? -17'sd16384 : r_phase;
        step_amt = StepW'(r_step) * StepW'(CONTACT_PERIOD);
        ph_sum   = $signed({{(SumW-17){ph_base[16]}}, ph_base})
                 + $signed({{(SumW-StepW){1'b0}}, step_amt});
    end

    // Contact decision and level for an evaluation sample.
    always_comb begin
        open_level = (r_scale > ONE_FX) ? 16'd0 : (ONE_FX - r_scale);
        if (pos < $signed({4'b0, r_low})) begin
            eval_closed = 1'b1;
        end else if (pos > $signed({4'b0, r_high})) begin
            eval_closed = 1'b0;
        end else begin
            eval_closed = !r_closed;
        end
        if (pos < $signed({4'b0, r_low})) begin
            eval_level = ONE_FX;
        end else if (pos > $signed({4'b0, r_high})) begin
            eval_level = 16'd0;
        end else begin
            eval_level = eval_closed ? ONE_FX : open_level;
        end
    end

    // Starting phase of a trigger.
    assign trig_diff = 18'sd32768 - $signed({2'b0, r_high});

    // Next state for the request in the input register.
    always_comb begin
        n_amp     = r_amp;
        n_phase   = r_phase;
        n_closed  = r_closed;
        n_held    = r_held;
        n_pair    = r_pair;
        n_delay   = r_delay;
        n_budget  = r_budget;
        n_elapsed = r_elapsed;
        n_env     = 16'd0;
        n_status  = ST_DELAY;
        if (r_in.mode == MODE_TRIGGER) begin
            // Load a new envelope.
            n_amp     = vel_to_amp(r_in.velocity);
            n_phase   = (r_high == 16'd0) ? -17'sd16384 : trig_diff[17:1];
            n_closed  = 1'b0;
            n_held    = 16'd0;
            n_pair    = '0;
            n_delay   = r_in.start_delay;
            n_budget  = {1'b0, (r_in.start_delay > r_maxlen) ? r_in.start_delay : r_maxlen};
            n_elapsed = 17'd0;
        end else if (r_delay != 16'd0) begin
            // Silence while the start delay runs out.
            n_delay = r_delay - 16'd1;
        end else begin
            // Bouncing: evaluate on the first sample of each contact period.
            if (r_pair == '0) begin
                if (wrap) begin
                    n_amp = dec_amp[16] ? 16'hFFFF : dec_amp[15:0];
                end
                if (ph_sum > PhMax) begin
                    n_phase = 17'sd65535;
                end else if (ph_sum < PhMin) begin
                    n_phase = -17'sd65536;
                end else begin
                    n_phase = ph_sum[16:0];
                end
                n_closed = eval_closed;
                n_held   = eval_level;
            end
            n_env     = n_held;
            n_pair    = (r_pair == PairLast) ? '0 : r_pair + PairW'(1);
            n_elapsed = (r_elapsed < CNT17_MAX) ? r_elapsed + 17'd1 : r_elapsed;
            n_budget  = (r_budget != 17'd0) ? r_budget - 17'd1 : r_budget;
            if ((n_elapsed > {1'b0, r_ramp})
                    && ((n_amp < r_low) || (n_budget == 17'd0))) begin
                n_status = ST_DONE;
            end else begin
                n_status = ST_BOUNCE;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high   <= RST_HIGH;
            r_low    <= RST_LOW;
            r_step   <= RST_STEP;
            r_decay  <= RST_DECAY;
            r_scale  <= RST_SCALE;
            r_ramp   <= RST_RAMP;
            r_maxlen <= RST_MAXLEN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HIGH:   r_high   <= i_cfg_data;
                REG_LOW:    r_low    <= i_cfg_data;
                REG_STEP:   r_step   <= i_cfg_data[13:0];
                REG_DECAY:  r_decay  <= i_cfg_data;
                REG_SCALE:  r_scale  <= i_cfg_data;
                REG_RAMP:   r_ramp   <= i_cfg_data;
                REG_MAXLEN: r_maxlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.mode        <= s_axis_tuser;
            r_in.velocity    <= $signed(s_axis_tdata[7:0]);
            r_in.start_delay <= s_axis_tdata[23:8];
        end
    end

    // Envelope state, updated once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp     <= 16'd0;
            r_phase   <= 17'sd0;
            r_closed  <= 1'b0;
            r_held    <= 16'd0;
            r_pair    <= '0;
            r_delay   <= 16'd0;
            r_budget  <= 17'd0;
            r_elapsed <= 17'd0;
        end else if (fire) begin
            r_amp     <= n_amp;
            r_phase   <= n_phase;
            r_closed  <= n_closed;
            r_held    <= n_held;
            r_pair    <= n_pair;
            r_delay   <= n_delay;
            r_budget  <= n_budget;
            r_elapsed <= n_elapsed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_env    <= n_env;
            r_out_status <= n_status;
        end
    end

endmodule

// ----- sim/tb_contact_bounce_envelope_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_contact_bounce_envelope_top
// Self-checking bench for the contact bounce envelope generator.
// ============================================================================
// Trigger and tick requests go in on the input stream. Every accepted request
// updates a local copy of the envelope state and pushes the expected sample
// and status. Each output sample is checked against the oldest one pushed.
// A short directed part covers the velocity extremes, the long start delay,
// ticks sent before any trigger and the all-zero-but-budget register setting. Random
// traffic then runs under several register settings and flow-control mixes.
// ============================================================================
module tb_contact_bounce_envelope_top;
    import cbe_pkg::*;

    localparam int CONTACT_PERIOD = 2;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        logic [15:0] envelope;
        logic [1:0]  status;
    } t_env_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [7:0] velocity, [23:8] start_delay
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] envelope
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Register copies used by the envelope predictor.
    logic [15:0] cfg_high   = RST_HIGH;
    logic [15:0] cfg_low    = RST_LOW;
    logic [13:0] cfg_step   = RST_STEP;
    logic [15:0] cfg_decay  = RST_DECAY;
    logic [15:0] cfg_scale  = RST_SCALE;
    logic [15:0] cfg_ramp   = RST_RAMP;
    logic [15:0] cfg_maxlen = RST_MAXLEN;

    // Envelope state copies.
    logic [15:0]        amp_q            = '0;
    logic signed [16:0] phase_q          = '0;
    logic               contact_closed_q = 1'b0;
    logic [15:0]        held_level       = '0;
    int                 sub_sample       = 0;
    logic [15:0]        delay_cnt        = '0;
    logic [16:0]        budget_cnt       = '0;
    logic [16:0]        elapsed_cnt      = '0;

    t_env_sample expected_samples[$];
    t_env_sample oldest_sample;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;

    contact_bounce_envelope_top #(
        .CONTACT_PERIOD(CONTACT_PERIOD)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, in case the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_contact_bounce_envelope_top: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Compare each accepted sample with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: sample with none expected, envelope %0d status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                oldest_sample = expected_samples.pop_front();
                if (m_axis_tdata !== oldest_sample.envelope) begin
                    $display("%0t: envelope mismatch, expected %0d, actual %0d",
                             $time, oldest_sample.envelope, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== oldest_sample.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, oldest_sample.status, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Advance the predicted envelope by one request and queue its sample.
    task automatic predict_envelope(input logic mode, input logic signed [7:0] vel,
                                    input logic [15:0] dly);
        t_env_sample sample;
        int          vel_i;
        int          ph_i;
        longint      ph;
        longint      tri_v;
        longint      pos;
        longint      amp_next;
        longint      low_l;
        longint      high_l;
        sample.envelope = '0;
        sample.status   = ST_DELAY;
        if (mode == MODE_TRIGGER) begin
            // A trigger restarts the envelope; negative velocity gives zero amplitude.
            vel_i = vel;
            amp_q = (vel_i <= 0) ? 16'd0 : 16'((vel_i * 32768) / 127);
            ph_i  = 32768 - int'(cfg_high);
            phase_q = (cfg_high != 0) ? 17'(ph_i >>> 1) : 17'(-16384);
            contact_closed_q = 1'b0;
            held_level  = '0;
            sub_sample  = 0;
            delay_cnt   = dly;
            budget_cnt  = (dly > cfg_maxlen) ? 17'(dly) : 17'(cfg_maxlen);
            elapsed_cnt = '0;
        end else if (delay_cnt != 0) begin
            delay_cnt = delay_cnt - 16'd1;
        end else begin
            // The contact position is evaluated on the first sample of a period.
            if (sub_sample == 0) begin
                ph    = phase_q;
                tri_v = (ph < 0) ? 32768 + 2 * ph : 32768 - 2 * ph;
                pos   = (longint'(amp_q) * tri_v) / 32768;
                if (ph > 16384) begin
                    amp_next = (longint'(amp_q) * longint'(cfg_decay)) >>> 15;
                    amp_q    = (amp_next > 65535) ? 16'hFFFF : 16'(amp_next);
                    ph       = -16384;
                end
                ph = ph + CONTACT_PERIOD * longint'(cfg_step);
                if (ph > PHASE_MAX_I) ph = PHASE_MAX_I;
                if (ph < PHASE_MIN_I) ph = PHASE_MIN_I;
                phase_q = 17'(ph);
                low_l  = cfg_low;
                high_l = cfg_high;
                if (pos < low_l) begin
                    contact_closed_q = 1'b1;
                    held_level       = ONE_FX;
                end else if (pos > high_l) begin
                    contact_closed_q = 1'b0;
                    held_level       = '0;
                end else begin
                    // Fast bounce between closed and the partly open level.
                    contact_closed_q = !contact_closed_q;
                    if (contact_closed_q) begin
                        held_level = ONE_FX;
                    end else begin
                        held_level = (cfg_scale > ONE_FX) ? 16'd0 : ONE_FX - cfg_scale;
                    end
                end
            end
            sample.envelope = held_level;
            sub_sample = (sub_sample + 1 >= CONTACT_PERIOD) ? 0 : sub_sample + 1;
            if (elapsed_cnt < CNT17_MAX) elapsed_cnt = elapsed_cnt + 17'd1;
            if (budget_cnt != 0) budget_cnt = budget_cnt - 17'd1;
            if (elapsed_cnt > 17'(cfg_ramp) && (amp_q < cfg_low || budget_cnt == 0)) begin
                sample.status = ST_DONE;
            end else begin
                sample.status = ST_BOUNCE;
            end
        end
        expected_samples.push_back(sample);
    endtask

    // Offer one request, with random idle cycles ahead of it.
    task automatic send_request(input logic mode, input logic signed [7:0] vel,
                                input logic [15:0] dly);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dly, vel};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_envelope(mode, vel, dly);
    endtask

    // Stop sending and wait until every expected sample has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    // One register write; the predictor copy changes when it is accepted.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_HIGH:   cfg_high   = value;
            REG_LOW:    cfg_low    = value;
            REG_STEP:   cfg_step   = value[13:0];
            REG_DECAY:  cfg_decay  = value;
            REG_SCALE:  cfg_scale  = value;
            REG_RAMP:   cfg_ramp   = value;
            REG_MAXLEN: cfg_maxlen = value;
            default: ;
        endcase
    endtask

    // Load all seven registers once the block has gone idle.
    task automatic write_setting(input logic [15:0] high, input logic [15:0] low,
                                 input logic [13:0] step, input logic [15:0] dec,
                                 input logic [15:0] scl, input logic [15:0] ramp,
                                 input logic [15:0] maxlen);
        wait_drained();
        write_reg(REG_HIGH, high);
        write_reg(REG_LOW, low);
        write_reg(REG_STEP, 16'(step));
        write_reg(REG_DECAY, dec);
        write_reg(REG_SCALE, scl);
        write_reg(REG_RAMP, ramp);
        write_reg(REG_MAXLEN, maxlen);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_random_setting();
        write_setting(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 4000)),
                      ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 8192))
                                                  : 14'($urandom_range(200, 3000)),
                      16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                      16'($urandom_range(0, 150)), 16'($urandom_range(1, 200)));
    endtask

    // Ticks before any trigger run from the reset state.
    task automatic test_ticks_from_reset();
        repeat (3) send_request(MODE_TICK, 8'($urandom), 16'($urandom));
    endtask

    // Velocity extremes, clamped negative velocity and the longest delay.
    task automatic test_velocity_extremes();
        send_request(MODE_TRIGGER, 8'sd127, 16'd0);
        repeat (6) send_request(MODE_TICK, 8'sd0, 16'd0);
        send_request(MODE_TRIGGER, -8'sd128, 16'd2);
        repeat (3) send_request(MODE_TICK, -8'sd1, 16'hFFFF);
        send_request(MODE_TRIGGER, 8'sd0, 16'hFFFF);
        send_request(MODE_TICK, 8'sd127, 16'd0);
        send_request(MODE_TRIGGER, 8'sd1, 16'd0);
        send_request(MODE_TICK, 8'sd0, 16'd0);
        send_request(MODE_TRIGGER, 8'sd64, 16'd1);
        send_request(MODE_TRIGGER, -8'sd1, 16'd0);
    endtask

    // All registers but the budget at zero: zero high threshold, budget of one sample.
    task automatic test_zero_settings();
        write_setting(16'd0, 16'd0, 14'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        send_request(MODE_TRIGGER, 8'sd127, 16'd1);
        repeat (4) send_request(MODE_TICK, 8'sd0, 16'd0);
    endtask

    // Mostly trigger-then-ticks sequences with random content, plus stray requests.
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int                 sent;
        int                 n_extra;
        logic signed [7:0]  vel;
        logic [15:0]        dly;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                n_extra = $urandom_range(1, 6);
                repeat (n_extra) begin
                    send_request(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
                end
                sent += n_extra;
            end else begin
                vel = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(1, 127));
                dly = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
                                                  : 16'($urandom_range(0, 6));
                n_extra = $urandom_range(1, 120);
                send_request(MODE_TRIGGER, vel, dly);
                repeat (n_extra) send_request(MODE_TICK, 8'($urandom), 16'($urandom));
                sent += n_extra + 1;
            end
            // Now and then hold off until every sample is back, mid-envelope.
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_TICK;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_HIGH;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ticks_from_reset();
        test_velocity_extremes();
        test_zero_settings();

        write_random_setting();
        test_random_phase(0, 0, 200);
        write_setting(16'd32768, 16'd32768, 14'd8192, 16'd32768, 16'd32768,
                      16'd65535, 16'd65535);
        test_random_phase(49, 0, 200);
        write_random_setting();
        test_random_phase(0, 49, 200);
        write_setting(RST_HIGH, RST_LOW, RST_STEP, RST_DECAY, RST_SCALE,
                      RST_RAMP, RST_MAXLEN);
        test_random_phase(7, 7, 200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("tb_contact_bounce_envelope_top: PASS");
        end else begin
            $display("tb_contact_bounce_envelope_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cbe_pkg.sv
rtl/core/contact_bounce_envelope_top.sv
sim/tb_contact_bounce_envelope_top.sv
